[hdl/dmtq_pkg.sv]
// shared types and codes for the deadline message and timer queue
package dmtq_pkg;
    localparam logic [31:0] T_INF = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_POST = 2'd0,
        CMD_TICK = 2'd1,
        CMD_TAKE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DIRECT  = 3'd0,
        ST_QREADY  = 3'd1,
        ST_QTIMER  = 3'd2,
        ST_FULL    = 3'd3,
        ST_TICK    = 3'd4,
        ST_POPPED  = 3'd5,
        ST_EMPTY   = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] key;
        logic [31:0] oth;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t ent;
    } qctl_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = (s >= {1'b0, T_INF}) ? T_INF : s[31:0];
    endfunction
endpackage

[hdl/dmtq_cell.sv]
// one slot of a sorted shift queue
module dmtq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  dmtq_pkg::qctl_t   ctl,
    input  logic              left_valid,
    input  logic              left_goes,
    input  dmtq_pkg::entry_t  left_ent,
    input  logic              right_valid,
    input  dmtq_pkg::entry_t  right_ent,
    output logic              valid,
    output logic              goes,
    output dmtq_pkg::entry_t  ent
);
    logic             valid_reg, valid_next;
    dmtq_pkg::entry_t ent_reg, ent_next;

    // new entry goes after equal keys: this slot's entry is displaced if its key is greater
    assign goes  = valid_reg && (ent_reg.key > ctl.ent.key);
    assign valid = valid_reg;
    assign ent   = ent_reg;

    always_comb begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (ctl.pop) begin
            valid_next = right_valid;
            ent_next   = right_ent;
        end else if (ctl.ins) begin
            if (goes) begin
                if (left_goes) ent_next = left_ent;
                else           ent_next = ctl.ent;
            end else if (!valid_reg && left_valid && !left_goes) begin
                valid_next = 1'b1;
                ent_next   = ctl.ent;
            end else if (!valid_reg && left_goes) begin
                valid_next = 1'b1;
                ent_next   = left_ent;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        ent_reg <= ent_next;
    end
endmodule

[hdl/dmtq_queue.sv]
// sorted queue built as a row of cells
module dmtq_queue #(
    parameter int SLOTS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dmtq_pkg::qctl_t   ctl,
    output dmtq_pkg::entry_t  head,
    output logic              nonempty,
    output logic              full,
    output logic [$clog2(SLOTS+1)-1:0] count
);
    localparam int CW = $clog2(SLOTS + 1);
    logic             v [SLOTS+1];
    logic             g [SLOTS+1];
    dmtq_pkg::entry_t e [SLOTS+1];
    logic [CW-1:0]    count_reg;

    // slot -1: always valid, never displaced, so slot 0 takes the new entry if empty
    assign v[0] = 1'b1;
    assign g[0] = 1'b0;
    assign e[0] = ctl.ent;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        dmtq_pkg::entry_t rent;
        logic             rv;
        if (i == SLOTS - 1) begin : g_end
            assign rv   = 1'b0;
            assign rent = e[i+1];
        end else begin : g_mid
            assign rv   = v[i+2];
            assign rent = e[i+2];
        end
        dmtq_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
            .left_valid(v[i]), .left_goes(g[i]), .left_ent(e[i]),
            .right_valid(rv), .right_ent(rent),
            .valid(v[i+1]), .goes(g[i+1]), .ent(e[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.pop) begin
            count_reg <= count_reg - CW'(1);
        end else if (ctl.ins) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    assign head     = e[1];
    assign nonempty = v[1];
    assign full     = (count_reg == CW'(SLOTS));
    assign count    = count_reg;
endmodule

[hdl/deadline_message_and_timer_queue.sv]
// top level of the earliest-deadline message scheduler
// Each queue is a row of cells that all act at once on an insert or pop. A
// post or take goes from accept through the done state to the result register;
// a tick moves due timer entries to the ready queue one at a time until none is
// due or the ready queue is full. One command is worked on at a time; the next is
// taken only after the previous result has left the output register.
module deadline_message_and_timer_queue #(
    parameter int QUEUE_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], msg_tag[9:2], after[41:10], within_req[73:42],
    // parent_baseline[105:74], parent_deadline[137:106], now[169:138]
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], out_tag[10:3], out_baseline[42:11], out_deadline[74:43],
    // timer_armed[75], timer_match[107:76], ready_count[112:108],
    // timer_count[117:113]
    output logic [119:0] m_tdata
);
    localparam int CW = $clog2(QUEUE_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TICK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]  cmd;
    logic [7:0]  tag;
    logic [31:0] after, within_req, pbl, pdl, now;
    assign cmd        = s_tdata[1:0];
    assign tag        = s_tdata[9:2];
    assign after      = s_tdata[41:10];
    assign within_req = s_tdata[73:42];
    assign pbl        = s_tdata[105:74];
    assign pdl        = s_tdata[137:106];
    assign now        = s_tdata[169:138];

    dmtq_pkg::qctl_t  rctl, tctl;
    dmtq_pkg::entry_t rhead, thead;
    logic rne, rfull, tne, tfull;
    logic [CW-1:0] rcnt, tcnt;

    dmtq_queue #(.SLOTS(QUEUE_SLOTS)) u_ready (
        .aclk(aclk), .aresetn(aresetn), .ctl(rctl), .head(rhead),
        .nonempty(rne), .full(rfull), .count(rcnt)
    );
    dmtq_queue #(.SLOTS(QUEUE_SLOTS)) u_timer (
        .aclk(aclk), .aresetn(aresetn), .ctl(tctl), .head(thead),
        .nonempty(tne), .full(tfull), .count(tcnt)
    );

    logic          m_valid_reg;
    logic [2:0]    st_reg, st_next;
    logic [7:0]    otag_reg, otag_next;
    logic [31:0]   obl_reg, obl_next, odl_reg, odl_next, now_reg;
    logic          accept;
    logic [31:0]   bl, dl;

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        bl = dmtq_pkg::sat_add(pbl, after);
        if (within_req != 32'd0) dl = dmtq_pkg::sat_add(bl, within_req);
        else if (bl < pdl)       dl = pdl;
        else                     dl = dmtq_pkg::T_INF;
    end

    always_comb begin
        state_next = state_reg;
        rctl = '0;
        tctl = '0;
        st_next = st_reg;
        otag_next = otag_reg;
        obl_next = obl_reg;
        odl_next = odl_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    otag_next = 8'd0;
                    obl_next  = 32'd0;
                    odl_next  = 32'd0;
                    state_next = S_DONE;
                    if (cmd[1]) begin
                        if (rne) begin
                            st_next   = dmtq_pkg::ST_POPPED;
                            otag_next = rhead.tag;
                            obl_next  = rhead.oth;
                            odl_next  = rhead.key;
                            rctl.pop  = 1'b1;
                        end else begin
                            st_next = dmtq_pkg::ST_EMPTY;
                        end
                    end else if (cmd[0]) begin
                        st_next    = dmtq_pkg::ST_TICK;
                        state_next = S_TICK;
                    end else begin
                        otag_next = tag;
                        if (after == 32'd0) begin
                            st_next  = dmtq_pkg::ST_DIRECT;
                            obl_next = pbl;
                            odl_next = pdl;
                        end else begin
                            obl_next = bl;
                            odl_next = dl;
                            if (now < bl) begin
                                st_next = tfull ? dmtq_pkg::ST_FULL : dmtq_pkg::ST_QTIMER;
                                tctl.ins = !tfull;
                                tctl.ent = '{tag: tag, key: bl, oth: dl};
                            end else begin
                                st_next = rfull ? dmtq_pkg::ST_FULL : dmtq_pkg::ST_QREADY;
                                rctl.ins = !rfull;
                                rctl.ent = '{tag: tag, key: dl, oth: bl};
                            end
                        end
                    end
                end
            end
            S_TICK: begin
                if (tne && thead.key <= now_reg && !rfull) begin
                    rctl.ins = 1'b1;
                    rctl.ent = '{tag: thead.tag, key: thead.oth, oth: thead.key};
                    tctl.pop = 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_DONE) m_valid_reg <= 1'b1;
            else if (m_tready)       m_valid_reg <= 1'b0;
        end
        st_reg   <= st_next;
        otag_reg <= otag_next;
        obl_reg  <= obl_next;
        odl_reg  <= odl_next;
        if (accept) now_reg <= now;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, 5'(tcnt), 5'(rcnt),
                       (tne ? thead.key : 32'd0), tne,
                       odl_reg, obl_reg, otag_reg, st_reg};

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !m_tvalid) else $error("result before work done");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("accept while busy");
    a_no_double_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rctl.ins && rctl.pop) && !(tctl.ins && tctl.pop)) else $error("queue op clash");
    a_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rctl.ins && rfull)) else $error("ready overflow");
endmodule

[bench/deadline_message_and_timer_queue_tb.sv]
// testbench for the deadline message and timer queue: directed and random commands checked by a scoreboard
`timescale 1ns / 1ps

module deadline_message_and_timer_queue_tb;

    localparam int SLOTS = 16;

    typedef struct {
        logic [7:0]  tag;
        logic [31:0] key;
        logic [31:0] oth;
    } slot_t;

    typedef struct packed {
        logic [1:0]  timer_count_pad;
        logic [4:0]  timer_count;
        logic [4:0]  ready_count;
        logic [31:0] timer_match;
        logic        timer_armed;
        logic [31:0] out_deadline;
        logic [31:0] out_baseline;
        logic [7:0]  out_tag;
        logic [2:0]  status;
    } reply_t;

    class sched_board;
        slot_t  rdy[$];
        slot_t  tmr[$];
        reply_t replies_due[$];
        int     errors;

        function bit sorted_put(ref slot_t q[$], input slot_t e);
            int pos;
            if (q.size() >= SLOTS) return 0;
            pos = 0;
            while (pos < q.size() && q[pos].key <= e.key) pos++;
            q.insert(pos, e);
            return 1;
        endfunction

        function void note_command(logic [175:0] d);
            reply_t r;
            slot_t e;
            logic [1:0] cmd;
            logic [31:0] aft, win, pbl, pdl, now;
            cmd = d[1:0];
            aft = d[41:10];
            win = d[73:42];
            pbl = d[105:74];
            pdl = d[137:106];
            now = d[169:138];
            r = '0;
            if (cmd == dmtq_pkg::CMD_POST) begin
                r.out_tag = d[9:2];
                if (aft == 0) begin
                    r.status = dmtq_pkg::ST_DIRECT;
                    r.out_baseline = pbl;
                    r.out_deadline = pdl;
                end else begin
                    r.out_baseline = dmtq_pkg::sat_add(pbl, aft);
                    if (win != 0) r.out_deadline = dmtq_pkg::sat_add(r.out_baseline, win);
                    else if (r.out_baseline < pdl) r.out_deadline = pdl;
                    else r.out_deadline = dmtq_pkg::T_INF;
                    e.tag = r.out_tag;
                    if (now < r.out_baseline) begin
                        e.key = r.out_baseline;
                        e.oth = r.out_deadline;
                        r.status = sorted_put(tmr, e) ? dmtq_pkg::ST_QTIMER
                                                      : dmtq_pkg::ST_FULL;
                    end else begin
                        e.key = r.out_deadline;
                        e.oth = r.out_baseline;
                        r.status = sorted_put(rdy, e) ? dmtq_pkg::ST_QREADY
                                                      : dmtq_pkg::ST_FULL;
                    end
                end
            end else if (cmd == dmtq_pkg::CMD_TICK) begin
                r.status = dmtq_pkg::ST_TICK;
                while (tmr.size() > 0 && tmr[0].key <= now) begin
                    e.tag = tmr[0].tag;
                    e.key = tmr[0].oth;
                    e.oth = tmr[0].key;
                    if (!sorted_put(rdy, e)) break;
                    void'(tmr.pop_front());
                end
            end else begin
                if (rdy.size() == 0) begin
                    r.status = dmtq_pkg::ST_EMPTY;
                end else begin
                    e = rdy.pop_front();
                    r.status = dmtq_pkg::ST_POPPED;
                    r.out_tag = e.tag;
                    r.out_baseline = e.oth;
                    r.out_deadline = e.key;
                end
            end
            r.timer_armed = tmr.size() != 0;
            r.timer_match = tmr.size() != 0 ? tmr[0].key : 32'd0;
            r.ready_count = 5'(rdy.size());
            r.timer_count = 5'(tmr.size());
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [119:0] d);
            reply_t got, want;
            got = reply_t'(d);
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", d);
                return;
            end
            want = replies_due.pop_front();
            if (got[117:0] !== want[117:0]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [119:0] m_tdata;

    sched_board board = new();
    int  cycles = 0;
    bit  hold_rx = 0;
    bit  rx_idle_ok = 1;
    bit  src_done = 0;
    logic [31:0] clock_now = 32'd100;

    deadline_message_and_timer_queue #(.QUEUE_SLOTS(SLOTS)) dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return dmtq_pkg::T_INF;
            2: return dmtq_pkg::T_INF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(logic [1:0] cmd, logic [7:0] tag, logic [31:0] aft,
                        logic [31:0] win, logic [31:0] pbl, logic [31:0] pdl,
                        logic [31:0] now);
        s_tdata <= {6'd0, now, pdl, pbl, win, aft, tag, cmd};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        board.note_command(s_tdata);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic post_near(logic [7:0] tag);
        logic [31:0] pbl;
        pbl = clock_now - $urandom_range(0, 30);
        send(dmtq_pkg::CMD_POST, tag, $urandom_range(1, 60),
             ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 80),
             pbl, ($urandom_range(0, 3) == 0) ? dmtq_pkg::T_INF : pbl + $urandom_range(0, 100),
             clock_now);
    endtask

    task automatic drain_wait();
        s_tvalid <= 0;
        while (board.replies_due.size() != 0) @(posedge aclk);
    endtask

    // result side: random stalls, always ready while rx_idle_ok is clear, or a long hold-off when asked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_reply(m_tdata);
            if (hold_rx) m_tready <= 0;
            else m_tready <= rx_idle_ok ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("[deadline_message_and_timer_queue] ERROR");
            $finish;
        end
    end

    initial begin
        int k;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed part
        send(dmtq_pkg::CMD_TAKE, 0, 0, 0, 0, 0, 0);
        send(dmtq_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0);
        send(dmtq_pkg::CMD_POST, 8'hFF, 0, 5, 32'h1234, dmtq_pkg::T_INF, 0);
        send(dmtq_pkg::CMD_POST, 8'h01, dmtq_pkg::T_INF, 0, dmtq_pkg::T_INF,
             dmtq_pkg::T_INF, dmtq_pkg::T_INF);
        send(dmtq_pkg::CMD_POST, 8'h02, 32'd1, dmtq_pkg::T_INF, 32'd10, 32'd5, 32'd0);
        send(dmtq_pkg::CMD_POST, 8'h03, 32'd1, 0, 32'd10, 32'd500, 32'd0);
        send(dmtq_pkg::CMD_POST, 8'h04, 32'd1, 0, 32'd10, 32'd500, 32'd0);
        send(dmtq_pkg::CMD_POST, 8'h05, 32'd1, 0, 32'd10, 32'd500, dmtq_pkg::T_INF);
        send(dmtq_pkg::CMD_POST, 8'h06, 32'd5, 0, 32'd10, 32'd5, 32'd20);
        send(2'd3, 0, dmtq_pkg::T_INF, dmtq_pkg::T_INF, dmtq_pkg::T_INF,
             dmtq_pkg::T_INF, dmtq_pkg::T_INF);
        send(dmtq_pkg::CMD_TICK, 0, 0, 0, 0, 0, 32'd11);
        send(dmtq_pkg::CMD_TICK, 0, 0, 0, 0, 0, dmtq_pkg::T_INF);
        for (k = 0; k < 12; k++) send(dmtq_pkg::CMD_TAKE, 0, 0, 0, 0, 0, 0);

        // fill the timer queue past full, then tick into a full ready queue
        for (k = 0; k < 18; k++)
            send(dmtq_pkg::CMD_POST, 8'(k), 32'd1000 + (k % 3), k, 32'd0, 32'd0, 32'd0);
        for (k = 0; k < 18; k++)
            send(dmtq_pkg::CMD_POST, 8'(8'h80 | k), 32'd1, k % 4, 32'd0, 32'd0, 32'd50);
        send(dmtq_pkg::CMD_TICK, 0, 0, 0, 0, 0, 32'd2000);
        for (k = 0; k < 4; k++) send(dmtq_pkg::CMD_TAKE, 0, 0, 0, 0, 0, 0);
        send(dmtq_pkg::CMD_TICK, 0, 0, 0, 0, 0, 32'd2000);
        drain_wait();

        // long receiver hold-off while the sender keeps offering
        hold_rx = 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_rx = 0;
            end
            for (k = 0; k < 20; k++) send(dmtq_pkg::CMD_TAKE, 0, 0, 0, 0, 0, 0);
        join
        drain_wait();

        // random part: mostly near-time traffic, some raw noise
        for (k = 0; k < 1000; k++) begin
            if (k % 200 == 100) rx_idle_ok = !rx_idle_ok;
            if ((k / 50) % 3 != 2) pause(gap_len());
            if ($urandom_range(0, 9) == 0) begin
                send(2'($urandom_range(0, 3)), 8'($urandom), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word());
            end else begin
                clock_now = clock_now + $urandom_range(0, 8);
                case ($urandom_range(0, 5))
                    0, 1, 2: post_near(8'($urandom));
                    3, 4: send(dmtq_pkg::CMD_TICK, 8'($urandom), $urandom, $urandom,
                               $urandom, $urandom, clock_now);
                    default: send(dmtq_pkg::CMD_TAKE, 8'($urandom), $urandom, $urandom,
                                  $urandom, $urandom, $urandom);
                endcase
            end
        end
        drain_wait();
        rx_idle_ok = 1;
        repeat (50) @(posedge aclk);

        if (board.errors == 0 && board.replies_due.size() == 0)
            $display("[deadline_message_and_timer_queue] OK");
        else
            $display("[deadline_message_and_timer_queue] ERROR");
        $finish;
    end
endmodule
